FILE: rtl/fdtd4_pkg.sv
// Shared constants and types for the fourth-order FDTD field update unit.
package fdtd4_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 18;
  localparam int COEF_W     = 18;
  localparam int SIZE_W     = 7;
  localparam int DIM_W      = 2;

  typedef logic [CFG_ADDR_W-1:0] cfg_addr_t;

  // Configuration register indexes.
  localparam cfg_addr_t CFG_C1     = 3'd0;
  localparam cfg_addr_t CFG_C2     = 3'd1;
  localparam cfg_addr_t CFG_SIZE_X = 3'd2;
  localparam cfg_addr_t CFG_SIZE_Y = 3'd3;
  localparam cfg_addr_t CFG_SIZE_Z = 3'd4;
  localparam cfg_addr_t CFG_DIMS   = 3'd5;

  // Register values after reset.
  localparam logic [SIZE_W-1:0] SIZE_X_RST = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_Y_RST = 7'd64;
  localparam logic [SIZE_W-1:0] SIZE_Z_RST = 7'd1;
  localparam logic [DIM_W-1:0]  DIM_3D     = 2'd3;

endpackage

FILE: rtl/fdtd4_dly.sv
// Item-clocked delay line on a circular buffer with a run-time read lag.
module fdtd4_dly #(
  parameter int DEPTH = 4,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic [$clog2(DEPTH)-1:0] lag,
  input  logic [WIDTH-1:0]         din,
  output logic [WIDTH-1:0]         dout
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_V = (AW+1)'(DEPTH);
  localparam logic [AW-1:0] LAST_A = AW'(DEPTH - 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] dout_r;
  logic [AW-1:0]    wp_r;
  logic [AW-1:0]    wp_nxt;
  logic [AW:0]      rp_wide;

  // Read lag entries behind the write pointer, wrapping around the buffer.
  always_comb begin
    if ({1'b0, wp_r} >= {1'b0, lag}) begin
      rp_wide = {1'b0, wp_r} - {1'b0, lag};
    end else begin
      rp_wide = {1'b0, wp_r} + DEPTH_V - {1'b0, lag};
    end
    wp_nxt = (wp_r == LAST_A) ? '0 : wp_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
    end else if (en) begin
      wp_r <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mem[wp_r] <= din;
      dout_r    <= mem[rp_wide[AW-1:0]];
    end
  end

  assign dout = dout_r;

endmodule

FILE: rtl/fdtd4_field_update_unit.sv
// Fourth-order FDTD curl update over a streamed padded grid.
// A result passes the difference, product and output registers after its window completes.
// One request per cycle unless stalled; each line and plane buffer takes one write and one read.
// A stalled result holds in the output register and stops the pipeline and in_tready.
// Reset (rst_n low at a clock edge) clears the valid bits, pass position and config registers;
// buffer contents stay undefined until the stream has filled them.
module fdtd4_field_update_unit #(
  parameter int MAX_X      = 64,
  parameter int MAX_Y      = 64,
  parameter int MAX_Z      = 64,
  parameter int HALO       = 2,
  parameter int FIELD_BITS = 32
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  cfg_we,
  input  logic [fdtd4_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [fdtd4_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // src_x, src_y, src_z, dst_x, dst_y, dst_z from the lowest bit up, zero padded.
  input  logic [((6*FIELD_BITS+7)/8)*8-1:0]     in_tdata,
  // op: 0 updates E at full step, 1 updates B at half step.
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // upd_x, upd_y, upd_z from the lowest bit up, zero padded.
  output logic [((3*FIELD_BITS+7)/8)*8-1:0]     out_tdata,
  // last_cell: the final interior cell of the pass.
  output logic                                  out_tlast
);

  localparam int FB   = FIELD_BITS;
  localparam int SW   = 3*FB;
  localparam int OUT_W = ((3*FIELD_BITS+7)/8)*8;
  localparam int DW   = FB + 2;
  localparam int PW   = DW + fdtd4_pkg::COEF_W;
  localparam int SUMW = PW + 1;

  localparam int PXM = MAX_X + 2*HALO;
  localparam int PYM = MAX_Y + 2*HALO;
  localparam int PZM = MAX_Z + 2*HALO;
  localparam int PX_W = $clog2(PXM+1);
  localparam int PY_W = $clog2(PYM+1);
  localparam int PZ_W = $clog2(PZM+1);

  localparam int PL_DEPTH = PXM*PYM;
  localparam int RL_DEPTH = PXM;
  localparam int ZD_DEPTH = 2*PXM + 2;
  localparam int DL_DEPTH = 2*PXM*PYM + 2*PXM + 2;
  localparam int PL_AW = $clog2(PL_DEPTH);
  localparam int RL_AW = $clog2(RL_DEPTH);
  localparam int ZD_AW = $clog2(ZD_DEPTH);
  localparam int DL_AW = $clog2(DL_DEPTH);
  localparam int GEO_W = $clog2(DL_DEPTH+1);

  localparam logic signed [SUMW-1:0] RND_FULL = SUMW'(32768);
  localparam logic signed [SUMW-1:0] RND_HALF = SUMW'(65536);
  localparam logic signed [SUMW-1:0] F_MAX = (SUMW'(1) <<< (FB-1)) - SUMW'(1);
  localparam logic signed [SUMW-1:0] F_MIN = -(SUMW'(1) <<< (FB-1));

  // Configuration registers.
  logic signed [fdtd4_pkg::COEF_W-1:0] c1_r, c2_r;
  logic [fdtd4_pkg::SIZE_W-1:0]        sx_r, sy_r, sz_r;
  logic [fdtd4_pkg::DIM_W-1:0]         dim_r;
  logic                                geo_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_r  <= '0;
      c2_r  <= '0;
      sx_r  <= fdtd4_pkg::SIZE_X_RST;
      sy_r  <= fdtd4_pkg::SIZE_Y_RST;
      sz_r  <= fdtd4_pkg::SIZE_Z_RST;
      dim_r <= fdtd4_pkg::DIM_3D;
    end else if (cfg_we) begin
      case (cfg_addr)
        fdtd4_pkg::CFG_C1:     c1_r  <= cfg_wdata;
        fdtd4_pkg::CFG_C2:     c2_r  <= cfg_wdata;
        fdtd4_pkg::CFG_SIZE_X: sx_r  <= cfg_wdata[fdtd4_pkg::SIZE_W-1:0];
        fdtd4_pkg::CFG_SIZE_Y: sy_r  <= cfg_wdata[fdtd4_pkg::SIZE_W-1:0];
        fdtd4_pkg::CFG_SIZE_Z: sz_r  <= cfg_wdata[fdtd4_pkg::SIZE_W-1:0];
        fdtd4_pkg::CFG_DIMS:   dim_r <= cfg_wdata[fdtd4_pkg::DIM_W-1:0];
        default: ;
      endcase
    end
  end

  // Any geometry write restarts the pass at the first padded cell.
  always_comb begin
    case (cfg_addr)
      fdtd4_pkg::CFG_SIZE_X,
      fdtd4_pkg::CFG_SIZE_Y,
      fdtd4_pkg::CFG_SIZE_Z,
      fdtd4_pkg::CFG_DIMS:   geo_wr = cfg_we;
      default:               geo_wr = 1'b0;
    endcase
  end

  // Effective geometry. A size of zero counts as one, an oversize counts as the maximum.
  logic            three;
  logic [PX_W-1:0] sx_c, px_c;
  logic [PY_W-1:0] sy_c, py_c;
  logic [PZ_W-1:0] sz_c, pz_c;
  logic [GEO_W-1:0] plane_sz, dst_dist;

  always_comb begin
    three = (dim_r == fdtd4_pkg::DIM_3D);
    if (sx_r == '0) begin
      sx_c = PX_W'(1);
    end else if (32'(sx_r) > 32'(MAX_X)) begin
      sx_c = PX_W'(MAX_X);
    end else begin
      sx_c = PX_W'(sx_r);
    end
    if (sy_r == '0) begin
      sy_c = PY_W'(1);
    end else if (32'(sy_r) > 32'(MAX_Y)) begin
      sy_c = PY_W'(MAX_Y);
    end else begin
      sy_c = PY_W'(sy_r);
    end
    if (sz_r == '0) begin
      sz_c = PZ_W'(1);
    end else if (32'(sz_r) > 32'(MAX_Z)) begin
      sz_c = PZ_W'(MAX_Z);
    end else begin
      sz_c = PZ_W'(sz_r);
    end
    px_c = sx_c + PX_W'(2*HALO);
    py_c = sy_c + PY_W'(2*HALO);
    pz_c = three ? sz_c + PZ_W'(2*HALO) : PZ_W'(1);
    plane_sz = GEO_W'(px_c) * GEO_W'(py_c);
    // The target value of the center cell lies this many requests back.
    dst_dist = (three ? (plane_sz << 1) : '0) + (GEO_W'(px_c) << 1) + GEO_W'(2);
  end

  // Pipeline advance: the stage registers move unless a result is waiting on a stalled sink.
  logic out_valid_r;
  logic en, acc;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign acc       = in_tvalid && en;

  // Pass position of the arriving request.
  logic [PX_W-1:0] pos_x_r;
  logic [PY_W-1:0] pos_y_r;
  logic [PZ_W-1:0] pos_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n || geo_wr) begin
      pos_x_r <= '0;
      pos_y_r <= '0;
      pos_z_r <= '0;
    end else if (acc) begin
      if (pos_x_r == px_c - PX_W'(1)) begin
        pos_x_r <= '0;
        if (pos_y_r == py_c - PY_W'(1)) begin
          pos_y_r <= '0;
          pos_z_r <= (pos_z_r == pz_c - PZ_W'(1)) ? '0 : pos_z_r + PZ_W'(1);
        end else begin
          pos_y_r <= pos_y_r + PY_W'(1);
        end
      end else begin
        pos_x_r <= pos_x_r + PX_W'(1);
      end
    end
  end

  // The arriving request completes the window of the interior cell two cells back
  // along every active axis; that arriving position spans HALO+2 up to the padded size minus HALO-1.
  logic emit0, last0;

  always_comb begin
    emit0 = (pos_x_r >= PX_W'(HALO+2)) && (pos_x_r <= px_c - PX_W'(HALO-1)) &&
            (pos_y_r >= PY_W'(HALO+2)) && (pos_y_r <= py_c - PY_W'(HALO-1)) &&
            (!three || ((pos_z_r >= PZ_W'(HALO+2)) &&
                        (pos_z_r <= pz_c - PZ_W'(HALO-1))));
    last0 = (pos_x_r == px_c - PX_W'(HALO-1)) && (pos_y_r == py_c - PY_W'(HALO-1)) &&
            (!three || (pos_z_r == pz_c - PZ_W'(HALO-1)));
  end

  // Source window. A delay line with read lag L shows the request L+1 back.
  // Plane chain: pl[m] is the source m planes back, pl[0] the arriving request.
  logic [SW-1:0] src_in, dst_in;
  logic [SW-1:0] pl [5];
  logic [SW-1:0] rl [5];
  logic [SW-1:0] pc;
  logic [SW-1:0] zq [4];
  logic [SW-1:0] dst_q;
  logic [PL_AW-1:0] lag_pl;
  logic [RL_AW-1:0] lag_rl;
  logic [ZD_AW-1:0] lag_zd;
  logic [DL_AW-1:0] lag_dl;

  assign src_in = in_tdata[SW-1:0];
  assign dst_in = in_tdata[2*SW-1:SW];
  assign pl[0]  = src_in;
  assign lag_pl = PL_AW'(plane_sz - GEO_W'(1));
  assign lag_rl = RL_AW'(px_c - PX_W'(1));
  assign lag_zd = ZD_AW'((GEO_W'(px_c) << 1) + GEO_W'(1));
  assign lag_dl = DL_AW'(dst_dist - GEO_W'(1));

  // The center plane feeds the row chain; in two-dimensional mode it is the arriving one.
  assign pc    = three ? pl[2] : src_in;
  assign rl[0] = pc;

  for (genvar k = 1; k < 5; k++) begin : g_chain
    fdtd4_dly #(.DEPTH(PL_DEPTH), .WIDTH(SW)) u_plane (
      .clk(clk), .rst_n(rst_n), .en(acc), .lag(lag_pl), .din(pl[k-1]), .dout(pl[k])
    );
    fdtd4_dly #(.DEPTH(RL_DEPTH), .WIDTH(SW)) u_row (
      .clk(clk), .rst_n(rst_n), .en(acc), .lag(lag_rl), .din(rl[k-1]), .dout(rl[k])
    );
  end

  // Z taps are whole planes away from the center; each is brought in line with the
  // center by a further two rows and two cells.
  logic [SW-1:0] zsrc [4];
  assign zsrc[0] = pl[4];
  assign zsrc[1] = pl[3];
  assign zsrc[2] = pl[1];
  assign zsrc[3] = pl[0];

  for (genvar k = 0; k < 4; k++) begin : g_ztap
    fdtd4_dly #(.DEPTH(ZD_DEPTH), .WIDTH(SW)) u_zdly (
      .clk(clk), .rst_n(rst_n), .en(acc), .lag(lag_zd), .din(zsrc[k]), .dout(zq[k])
    );
  end

  fdtd4_dly #(.DEPTH(DL_DEPTH), .WIDTH(SW)) u_dst (
    .clk(clk), .rst_n(rst_n), .en(acc), .lag(lag_dl), .din(dst_in), .dout(dst_q)
  );

  // Short shift lines: two cells on each row tap, four cells along the center row.
  logic [SW-1:0] yd1_r [5];
  logic [SW-1:0] yd2_r [5];
  logic [SW-1:0] xs_r  [1:4];

  always_ff @(posedge clk) begin
    if (acc) begin
      for (int n = 0; n < 5; n++) begin
        yd1_r[n] <= rl[n];
        yd2_r[n] <= yd1_r[n];
      end
      xs_r[1] <= rl[2];
      for (int k = 2; k < 5; k++) begin
        xs_r[k] <= xs_r[k-1];
      end
    end
  end

  // Taps per axis, index 0 at offset -2 up to index 4 at offset +2.
  logic [SW-1:0] tp [3][5];

  always_comb begin
    tp[0][4] = rl[2];
    for (int i = 0; i < 4; i++) begin
      tp[0][i] = xs_r[4-i];
    end
    for (int i = 0; i < 5; i++) begin
      tp[1][i] = yd2_r[4-i];
    end
    tp[1][2] = xs_r[2];
    tp[2][0] = zq[0];
    tp[2][1] = zq[1];
    tp[2][2] = xs_r[2];
    tp[2][3] = zq[2];
    tp[2][4] = zq[3];
  end

  // Near and wide differences of each component along each axis. Op 0 uses offsets
  // -2..+1, op 1 uses -1..+2; differences along z vanish in two-dimensional mode.
  logic signed [FB:0]   nd [3][3];
  logic signed [FB:0]   wd [3][3];
  logic signed [DW-1:0] d1_nxt [3];
  logic signed [DW-1:0] d2_nxt [3];

  always_comb begin
    logic signed [FB-1:0] t0, t1, t2, t3, t4;
    for (int c = 0; c < 3; c++) begin
      for (int a = 0; a < 3; a++) begin
        t0 = $signed(tp[a][0][c*FB +: FB]);
        t1 = $signed(tp[a][1][c*FB +: FB]);
        t2 = $signed(tp[a][2][c*FB +: FB]);
        t3 = $signed(tp[a][3][c*FB +: FB]);
        t4 = $signed(tp[a][4][c*FB +: FB]);
        if (a == 2 && !three) begin
          nd[c][a] = '0;
          wd[c][a] = '0;
        end else if (in_tuser) begin
          nd[c][a] = (FB+1)'(t3) - (FB+1)'(t2);
          wd[c][a] = (FB+1)'(t4) - (FB+1)'(t1);
        end else begin
          nd[c][a] = (FB+1)'(t1) - (FB+1)'(t2);
          wd[c][a] = (FB+1)'(t0) - (FB+1)'(t3);
        end
      end
    end
    // Curl: component c takes (c+1 along c+2) minus (c+2 along c+1).
    for (int c = 0; c < 3; c++) begin
      d1_nxt[c] = DW'(nd[(c+1)%3][(c+2)%3]) - DW'(nd[(c+2)%3][(c+1)%3]);
      d2_nxt[c] = DW'(wd[(c+1)%3][(c+2)%3]) - DW'(wd[(c+2)%3][(c+1)%3]);
    end
  end

  // Stage 1: curl differences.
  logic                 v1_r, op1_r, last1_r;
  logic signed [DW-1:0] d1_r [3];
  logic signed [DW-1:0] d2_r [3];
  logic [SW-1:0]        dst1_r;

  // Stage 2: weighted products.
  logic                 v2_r, op2_r, last2_r;
  logic signed [PW-1:0] p1_r [3];
  logic signed [PW-1:0] p2_r [3];
  logic signed [PW-1:0] p1_nxt [3];
  logic signed [PW-1:0] p2_nxt [3];
  logic [SW-1:0]        dst2_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      p1_nxt[c] = c1_r * d1_r[c];
      p2_nxt[c] = c2_r * d2_r[c];
    end
  end

  // Stage 3: round to nearest with ties upward, add the target, saturate.
  logic [SW-1:0] upd_nxt;

  always_comb begin
    logic signed [SUMW-1:0] sum_v, sh_v, res_v;
    for (int c = 0; c < 3; c++) begin
      sum_v = SUMW'(p1_r[c]) + SUMW'(p2_r[c]);
      if (op2_r) begin
        sh_v = (sum_v + RND_HALF) >>> 17;
      end else begin
        sh_v = (sum_v + RND_FULL) >>> 16;
      end
      res_v = sh_v + SUMW'($signed(dst2_r[c*FB +: FB]));
      if (res_v > F_MAX) begin
        res_v = F_MAX;
      end else if (res_v < F_MIN) begin
        res_v = F_MIN;
      end
      upd_nxt[c*FB +: FB] = res_v[FB-1:0];
    end
  end

  logic [SW-1:0] upd_r;
  logic          last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      v1_r        <= acc && emit0;
      v2_r        <= v1_r;
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op1_r   <= in_tuser;
      last1_r <= last0;
      dst1_r  <= dst_q;
      d1_r    <= d1_nxt;
      d2_r    <= d2_nxt;
      op2_r   <= op1_r;
      last2_r <= last1_r;
      dst2_r  <= dst1_r;
      p1_r    <= p1_nxt;
      p2_r    <= p2_nxt;
      upd_r   <= upd_nxt;
      last_r  <= last2_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'(upd_r);
  assign out_tlast  = last_r;

`ifndef NO_ASSERTIONS
  // The pass position never leaves the padded grid.
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_x_r < px_c) && (pos_y_r < py_c) && (pos_z_r < pz_c))
    else $error("pass position outside the padded grid");

  // A difference stage that advances always hands its cell to the product stage.
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v1_r) |=> v2_r)
    else $error("cell lost between difference and product stages");

  // A product stage that advances always presents its cell as a result.
  a_s2_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (en && v2_r) |=> out_tvalid)
    else $error("cell lost between product stage and output register");
`endif

endmodule
